// ----- rtl/htq_pkg.sv -----
package htq_pkg;
   localparam int unsigned TIME_BITS = 48;
   localparam int unsigned MAX_REPORTS = 16;

   typedef enum logic [1:0] {
      ACT_REGISTER = 2'd0,
      ACT_CANCEL   = 2'd1,
      ACT_TICK     = 2'd2,
      ACT_NONE     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_REGISTER = 2'd0,
      KIND_CANCEL   = 2'd1,
      KIND_EXPIRED  = 2'd2,
      KIND_SPARE    = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DROP,
      ST_EMIT
   } state_type;
endpackage

// ----- rtl/heap_timer_queue.sv -----
// heap_timer_queue: one-shot millisecond timer queue
// req channel: action (0 register, 1 cancel, 2 tick), duration_ms, timer_id
// rsp channel: kind, out_id, ok, last; one item per register or cancel item,
//   zero to sixteen expiry items per tick, soonest deadline first, ties to
//   the lower id, last marks the final item of each request
// register: result is valid the cycle after the request is accepted
// cancel scans every armed slot, one slot a cycle, then a drop step writes
//   its result into the output register
// a tick repeats that scan once per expiry, over the slots armed at that
//   moment, plus a closing scan that finds nothing due (skipped
//   when the queue runs empty or sixteen expiries are taken) and an emit
//   step; an expiry is held back until the next one is known, so it can carry last
// req_ready is high only while idle with the output register empty; one
//   request is worked at a time
// when the receiver stalls, a result waits in its output register; the
//   sequencer keeps scanning and stops in the drop step only while both the
//   held expiry and the output register are occupied
// reset clears time, count and id counter; slot storage is not cleared,
//   only the first count slots are ever read
module heap_timer_queue import htq_pkg::*; #(
   parameter int unsigned TIMER_SLOTS = 16,
   parameter int unsigned ID_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [31:0] req_duration_ms,
   input  logic [15:0] req_timer_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [15:0] rsp_out_id,
   output logic        rsp_ok,
   output logic        rsp_last
);
   localparam int unsigned SW = $clog2(TIMER_SLOTS);
   localparam int unsigned CW = $clog2(TIMER_SLOTS + 1);
   localparam logic [TIME_BITS-1:0] TMAX = '1;

   state_type state_ff, state_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [CW-1:0] count_ff, count_in;
   logic [ID_BITS-1:0] next_ff, next_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [4:0] nrep_ff, nrep_in;
   action_type act_ff, act_in;
   logic [15:0] key_ff, key_in;
   logic rv_ff, rv_in;
   logic [1:0] rk_ff, rk_in;
   logic [15:0] rid_ff, rid_in;
   logic rok_ff, rok_in, rl_ff, rl_in;
   // expiry held back until the next one is known
   logic pend_ff, pend_in;
   logic [15:0] pid_ff, pid_in;

   // slot storage, each slot register
   logic [TIME_BITS-1:0] dl_mem [TIMER_SLOTS];
   logic [ID_BITS-1:0] id_mem [TIMER_SLOTS];
   logic wr_en;
   logic [SW-1:0] wr_addr;
   logic [TIME_BITS-1:0] wr_dl;
   logic [ID_BITS-1:0] wr_id;

   logic scan_start, found;
   logic [SW-1:0] best;
   logic [TIME_BITS-1:0] best_dl;
   logic [ID_BITS-1:0] best_id;
   logic [TIME_BITS:0] sum;
   logic [SW-1:0] end_slot;
   logic [ID_BITS-1:0] key_ext;

   assign sum = {1'b0, now_ff} + {{(TIME_BITS - 31){1'b0}}, req_duration_ms};
   assign end_slot = SW'(count_ff - CW'(1));
   assign key_ext = ID_BITS'(key_ff);

   htq_scan #(.SLOTS(TIMER_SLOTS), .IW(ID_BITS)) u_scan (
      .clock(clock), .start(scan_start), .by_id(act_ff == ACT_CANCEL),
      .key_id(key_ext), .index(idx_ff), .slot_dl(dl_mem[idx_ff]),
      .slot_id(id_mem[idx_ff]), .found(found), .best(best),
      .best_dl(best_dl), .best_id(best_id)
   );

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dl_mem[wr_addr] <= wr_dl;
         id_mem[wr_addr] <= wr_id;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         now_ff   <= '0;
         count_ff <= '0;
         next_ff  <= '0;
         rv_ff    <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         now_ff   <= now_in;
         count_ff <= count_in;
         next_ff  <= next_in;
         rv_ff    <= rv_in;
         pend_ff  <= pend_in;
      end
      idx_ff  <= idx_in;
      nrep_ff <= nrep_in;
      act_ff  <= act_in;
      key_ff  <= key_in;
      rk_ff   <= rk_in;
      rid_ff  <= rid_in;
      rok_ff  <= rok_in;
      rl_ff   <= rl_in;
      pid_ff  <= pid_in;
   end

   always_comb begin
      state_in = state_ff;
      now_in = now_ff;
      count_in = count_ff;
      next_in = next_ff;
      idx_in = idx_ff;
      nrep_in = nrep_ff;
      act_in = act_ff;
      key_in = key_ff;
      rv_in = rv_ff && !rsp_ready;
      rk_in = rk_ff;
      rid_in = rid_ff;
      rok_in = rok_ff;
      rl_in = rl_ff;
      pend_in = pend_ff;
      pid_in = pid_ff;
      req_ready = 1'b0;
      wr_en = 1'b0;
      wr_addr = count_ff[SW-1:0];
      wr_dl = sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0];
      wr_id = next_ff;
      scan_start = (idx_ff == '0);
      case (state_ff)
         ST_IDLE: begin
            req_ready = !rv_ff;
            idx_in = '0;
            nrep_in = '0;
            pend_in = 1'b0;
            if (req_valid && !rv_ff) begin
               act_in = action_type'(req_action);
               key_in = req_timer_id;
               case (action_type'(req_action))
                  ACT_REGISTER: begin
                     rv_in = 1'b1;
                     rk_in = KIND_REGISTER;
                     rl_in = 1'b1;
                     if (count_ff >= CW'(TIMER_SLOTS)) begin
                        rid_in = '0;
                        rok_in = 1'b0;
                     end else begin
                        wr_en = 1'b1;
                        count_in = count_ff + CW'(1);
                        next_in = next_ff + ID_BITS'(1);
                        rid_in = 16'(next_ff);
                        rok_in = 1'b1;
                     end
                  end
                  ACT_CANCEL: begin
                     if (count_ff == '0) begin
                        rv_in = 1'b1;
                        rk_in = KIND_CANCEL;
                        rid_in = req_timer_id;
                        rok_in = 1'b0;
                        rl_in = 1'b1;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  ACT_TICK: begin
                     if (now_ff != TMAX) now_in = now_ff + TIME_BITS'(1);
                     if (count_ff != '0) state_in = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            // one slot per cycle through the compare unit
            if (CW'(idx_ff) == count_ff - CW'(1)) begin
               state_in = ST_DROP;
            end else begin
               idx_in = idx_ff + SW'(1);
            end
         end
         ST_DROP: begin
            // idx holds while waiting so the scan result stays put
            if (act_ff == ACT_CANCEL) begin
               if (!rv_ff || rsp_ready) begin
                  idx_in = '0;
                  rv_in = 1'b1;
                  rk_in = KIND_CANCEL;
                  rid_in = key_ff;
                  rok_in = found;
                  rl_in = 1'b1;
                  if (found) begin
                     // move the final slot into the hole
                     wr_en = 1'b1;
                     wr_addr = best;
                     wr_dl = dl_mem[end_slot];
                     wr_id = id_mem[end_slot];
                     count_in = count_ff - CW'(1);
                  end
                  state_in = ST_IDLE;
               end
            end else if (best_dl > now_ff) begin
               // nothing more due: the held expiry is the final one
               idx_in = '0;
               if (pend_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (!pend_ff || !rv_ff || rsp_ready) begin
               idx_in = '0;
               if (pend_ff) begin
                  // another expiry follows, so the held one is not last
                  rv_in = 1'b1;
                  rk_in = KIND_EXPIRED;
                  rid_in = pid_ff;
                  rok_in = 1'b1;
                  rl_in = 1'b0;
               end
               pend_in = 1'b1;
               pid_in = 16'(best_id);
               wr_en = 1'b1;
               wr_addr = best;
               wr_dl = dl_mem[end_slot];
               wr_id = id_mem[end_slot];
               count_in = count_ff - CW'(1);
               nrep_in = nrep_ff + 5'd1;
               if ((count_ff == CW'(1)) || (nrep_ff == 5'(MAX_REPORTS - 1))) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_EMIT: begin
            // held expiry goes out with last
            if (!rv_ff || rsp_ready) begin
               rv_in = 1'b1;
               rk_in = KIND_EXPIRED;
               rid_in = pid_ff;
               rok_in = 1'b1;
               rl_in = 1'b1;
               pend_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid  = rv_ff;
   assign rsp_kind   = rk_ff;
   assign rsp_out_id = rid_ff;
   assign rsp_ok     = rok_ff;
   assign rsp_last   = rl_ff;
endmodule

// ----- rtl/htq_scan.sv -----
// sequential scan over the slots: one compare per cycle against the best so far
module htq_scan import htq_pkg::*; #(
   parameter int unsigned SLOTS = 16,
   parameter int unsigned IW = 16
) (
   input  logic                        clock,
   input  logic                        start,
   input  logic                        by_id,
   input  logic [IW-1:0]               key_id,
   input  logic [$clog2(SLOTS)-1:0]    index,
   input  logic [TIME_BITS-1:0]        slot_dl,
   input  logic [IW-1:0]               slot_id,
   output logic                        found,
   output logic [$clog2(SLOTS)-1:0]    best,
   output logic [TIME_BITS-1:0]        best_dl,
   output logic [IW-1:0]               best_id
);
   logic                     found_ff, found_in;
   logic [$clog2(SLOTS)-1:0] best_ff, best_in;
   logic [TIME_BITS-1:0]     dl_ff, dl_in;
   logic [IW-1:0]            id_ff, id_in;
   logic                     take;

   always_comb begin
      if (by_id) begin
         take = (slot_id == key_id) && (!found_ff || slot_dl < dl_ff);
      end else begin
         take = !found_ff || slot_dl < dl_ff || (slot_dl == dl_ff && slot_id < id_ff);
      end
      if (start) begin
         take = by_id ? (slot_id == key_id) : 1'b1;
      end
      found_in = (start ? 1'b0 : found_ff) | take;
      best_in  = take ? index : best_ff;
      dl_in    = take ? slot_dl : dl_ff;
      id_in    = take ? slot_id : id_ff;
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      best_ff  <= best_in;
      dl_ff    <= dl_in;
      id_ff    <= id_in;
   end

   assign found   = found_ff;
   assign best    = best_ff;
   assign best_dl = dl_ff;
   assign best_id = id_ff;
endmodule
